// ----- rtl/dual_threshold_transient_gate_assert.svh -----
// ----------------------------------------------------------------------------
// Transient gate assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef DUAL_THRESHOLD_TRANSIENT_GATE_ASSERT_SVH
`define DUAL_THRESHOLD_TRANSIENT_GATE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion, disabled while reset is asserted (active low).
`define DTTG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define DTTG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DTTG_ASSERT(lbl, clk, rstn, prop, msg)
`define DTTG_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/dttg_pkg.sv -----
// ----------------------------------------------------------------------------
// Transient gate package
// Shared widths, register indexes, reset values and types.
// ----------------------------------------------------------------------------
package dttg_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MARKER_W   = 20;
  localparam int unsigned SPAN_W     = 16;  // refractory, lead and delay
  localparam int unsigned FCNT_W     = 21;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOUD_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOUD_LEAD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_DELAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd6;

  // Threshold resets as 16-bit patterns (-2560 and -5120), truncated to width
  localparam logic [CFG_DATA_W-1:0] LOUD_THR_RST  = 32'd62976;
  localparam logic [CFG_DATA_W-1:0] QUIET_THR_RST = 32'd60416;
  localparam logic [FCNT_W-1:0]     FCNT_RST      = 21'd1048576;

  // Markers produced by one frame
  typedef struct packed {
    logic                loud_v;
    logic [MARKER_W-1:0] loud_frame;
    logic                quiet_v;
    logic [MARKER_W-1:0] quiet_frame;
  } dttg_res_t;

endpackage

// ----- rtl/dttg_in_if.sv -----
// ----------------------------------------------------------------------------
// Transient gate frame channel
// One frame level with its warp and new-track flags per item.
// ----------------------------------------------------------------------------
interface dttg_in_if #(
  parameter int unsigned LEVEL_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [LEVEL_BITS-1:0] level_db;
  logic                         warp_mark;
  logic                         new_track;

  modport source (output valid, level_db, warp_mark, new_track, input ready);
  modport sink   (input valid, level_db, warp_mark, new_track, output ready);
endinterface

// ----- rtl/dttg_out_if.sv -----
// ----------------------------------------------------------------------------
// Transient gate marker channel
// One accepted marker per item.
// ----------------------------------------------------------------------------
interface dttg_out_if
  import dttg_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MARKER_W-1:0] marker_frame;
  logic                is_loud;
  logic                last_in_run;

  modport source (output valid, marker_frame, is_loud, last_in_run, input ready);
  modport sink   (input valid, marker_frame, is_loud, last_in_run, output ready);
endinterface

// ----- rtl/dttg_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Transient gate configuration channel
// Register index and write data per write.
// ----------------------------------------------------------------------------
interface dttg_cfg_if
  import dttg_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/dttg_eval.sv -----
// ----------------------------------------------------------------------------
// Transient gate frame evaluation
// Crossing detection, refractory gating and marker shifting for one frame.
// ----------------------------------------------------------------------------
module dttg_eval
  import dttg_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 1048576,
  parameter int unsigned LEVEL_BITS = 16,
  parameter int unsigned FI_W       = 21,
  parameter int unsigned OA_W       = 21
) (
  // item
  input  logic signed [LEVEL_BITS-1:0] level_i,
  input  logic                         warp_i,
  input  logic                         new_track_i,
  // configuration
  input  logic                         enable_i,
  input  logic signed [LEVEL_BITS-1:0] loud_thr_i,
  input  logic signed [LEVEL_BITS-1:0] quiet_thr_i,
  input  logic [SPAN_W-1:0]            refr_i,
  input  logic [SPAN_W-1:0]            lead_i,
  input  logic [SPAN_W-1:0]            delay_i,
  input  logic [FCNT_W-1:0]            frame_count_i,
  // current state
  input  logic [FI_W-1:0]              fidx_i,
  input  logic signed [LEVEL_BITS-1:0] prev_i,
  input  logic                         have_prev_i,
  input  logic [OA_W-1:0]              loud_open_i,
  input  logic [OA_W-1:0]              quiet_open_i,
  // next state and markers
  output logic [FI_W-1:0]              fidx_o,
  output logic [OA_W-1:0]              loud_open_o,
  output logic [OA_W-1:0]              quiet_open_o,
  output dttg_res_t                    res_o
);

  localparam int unsigned CW = (OA_W > FCNT_W) ? OA_W : FCNT_W;

  logic [CW-1:0]   m, total, fc_ext, loud_open0, quiet_open0, loud_open1, loud_open2;
  logic [CW-1:0]   m_refr, m_lead, m_delay;
  logic [FI_W-1:0] m_fi;
  logic            have_prev, in_track, do_eval;
  logic            loud_x, quiet_x, loud_acc, quiet_acc;

  // A new track restarts at frame 0 with both paths open and no history
  assign m_fi        = new_track_i ? '0 : fidx_i;
  assign m           = CW'(m_fi);
  assign have_prev   = have_prev_i && !new_track_i;
  assign loud_open0  = new_track_i ? '0 : CW'(loud_open_i);
  assign quiet_open0 = new_track_i ? '0 : CW'(quiet_open_i);

  assign fc_ext   = CW'(frame_count_i);
  assign total    = (fc_ext > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : fc_ext;
  assign in_track = m < total;
  assign do_eval  = in_track && enable_i && have_prev;

  assign loud_x  = (level_i >= loud_thr_i) && (prev_i < loud_thr_i);
  assign quiet_x = (level_i <= quiet_thr_i) && (prev_i > quiet_thr_i);

  assign m_refr  = m + CW'(refr_i);
  assign m_lead  = m - CW'(lead_i);
  assign m_delay = m + CW'(delay_i);

  // Warp opens the loud path before this frame's crossings are judged
  assign loud_open1 = (in_track && warp_i) ? m : loud_open0;
  assign loud_acc   = do_eval && loud_x && (m >= loud_open1);
  assign loud_open2 = loud_acc ? m_refr : loud_open1;

  // Quiet waits on both trackers, including a loud accept of this frame
  assign quiet_acc = do_eval && quiet_x && (m >= quiet_open0) && (m >= loud_open2);

  assign loud_open_o  = OA_W'(loud_open2);
  assign quiet_open_o = OA_W'(quiet_acc ? m_refr : quiet_open0);
  assign fidx_o       = (m_fi < FI_W'(MAX_FRAMES)) ? m_fi + FI_W'(1) : m_fi;

  always_comb begin
    res_o.loud_v      = loud_acc && (m >= CW'(lead_i));
    res_o.loud_frame  = m_lead[MARKER_W-1:0];
    res_o.quiet_v     = quiet_acc && (m_delay < total);
    res_o.quiet_frame = m_delay[MARKER_W-1:0];
  end

endmodule

// ----- rtl/dual_threshold_transient_gate.sv -----
// ----------------------------------------------------------------------------
// Dual threshold transient gate
// Loud/quiet level crossing detector with refractory gating and shifting.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   - one frame per item: level_db (1/128 dB), warp_mark, new_track.
//   out_o  - zero, one or two markers per frame; loud before quiet, and
//            last_in_run flags the final marker of a frame.
//   cfg_i  - register writes (index, data), always ready; write only while
//            the block holds no frame and no undelivered marker.
// Timing:
//   A frame is registered on accept and evaluated from the stage register once
//   the result register can take its markers, which then load it. The first
//   marker is shown from the result register and is taken when out_o.ready is high.
//   Frames are taken one per cycle as long as each yields at most one marker
//   and the receiver keeps up; a frame with two markers holds the evaluation
//   stage while both wait, as the single marker output port shows one at a time.
// Reset:
//   Registers return to their documented defaults, the frame index and both
//   trackers clear, and the pipeline empties.
// Stall:
//   While out_o.ready is low a pending marker holds in the result register;
//   the evaluation stage then holds its frame, and in_i.ready drops once that stage is full.
// ----------------------------------------------------------------------------
`include "dual_threshold_transient_gate_assert.svh"

module dual_threshold_transient_gate
  import dttg_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 1048576,
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  dttg_in_if.sink  in_i,
  dttg_cfg_if.sink cfg_i,
  dttg_out_if.source out_o
);

  localparam int unsigned FI_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned OA_W = $clog2(MAX_FRAMES + (1 << SPAN_W));

  // Configuration registers
  logic                         enable_q;
  logic signed [LEVEL_BITS-1:0] loud_thr_q, quiet_thr_q;
  logic [SPAN_W-1:0]            refr_q, lead_q, delay_q;
  logic [FCNT_W-1:0]            fcnt_q;

  // Track state
  logic [FI_W-1:0]              fidx_q, fidx_d;
  logic signed [LEVEL_BITS-1:0] prev_q;
  logic                         have_prev_q;
  logic [OA_W-1:0]              loud_open_q, loud_open_d;
  logic [OA_W-1:0]              quiet_open_q, quiet_open_d;

  // Evaluation stage (input register)
  logic                         stg_v_q;
  logic signed [LEVEL_BITS-1:0] stg_level_q;
  logic                         stg_warp_q, stg_new_q;

  // Result register: up to one loud and one quiet marker
  logic                loud_v_q, quiet_v_q;
  logic [MARKER_W-1:0] loud_frame_q, quiet_frame_q;

  dttg_res_t res;
  logic      in_acc, pop, drains, fire;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      loud_thr_q  <= LOUD_THR_RST[LEVEL_BITS-1:0];
      quiet_thr_q <= QUIET_THR_RST[LEVEL_BITS-1:0];
      refr_q      <= '0;
      lead_q      <= '0;
      delay_q     <= '0;
      fcnt_q      <= FCNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ENABLE:      enable_q    <= cfg_i.data[0];
        REG_LOUD_THR:    loud_thr_q  <= cfg_i.data[LEVEL_BITS-1:0];
        REG_QUIET_THR:   quiet_thr_q <= cfg_i.data[LEVEL_BITS-1:0];
        REG_REFRACTORY:  refr_q      <= cfg_i.data[SPAN_W-1:0];
        REG_LOUD_LEAD:   lead_q      <= cfg_i.data[SPAN_W-1:0];
        REG_QUIET_DELAY: delay_q     <= cfg_i.data[SPAN_W-1:0];
        REG_FRAME_COUNT: fcnt_q      <= cfg_i.data[FCNT_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  // The stage may evaluate once the result register is empty or will be
  // empty after this cycle's pop, so it never has to hold three markers.
  assign pop    = out_o.valid && out_o.ready;
  assign drains = (!loud_v_q && !quiet_v_q) || (pop && !(loud_v_q && quiet_v_q));
  assign fire   = stg_v_q && drains;

  assign in_i.ready = !stg_v_q || fire;
  assign in_acc     = in_i.valid && in_i.ready;

  // Capture the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_level_q <= in_i.level_db;
      stg_warp_q  <= in_i.warp_mark;
      stg_new_q   <= in_i.new_track;
    end
  end

  // --------------------------------------------------------------------------
  // Evaluate one frame against the track state
  // --------------------------------------------------------------------------
  dttg_eval #(
    .MAX_FRAMES (MAX_FRAMES),
    .LEVEL_BITS (LEVEL_BITS),
    .FI_W       (FI_W),
    .OA_W       (OA_W)
  ) u_eval (
    .level_i       (stg_level_q),
    .warp_i        (stg_warp_q),
    .new_track_i   (stg_new_q),
    .enable_i      (enable_q),
    .loud_thr_i    (loud_thr_q),
    .quiet_thr_i   (quiet_thr_q),
    .refr_i        (refr_q),
    .lead_i        (lead_q),
    .delay_i       (delay_q),
    .frame_count_i (fcnt_q),
    .fidx_i        (fidx_q),
    .prev_i        (prev_q),
    .have_prev_i   (have_prev_q),
    .loud_open_i   (loud_open_q),
    .quiet_open_i  (quiet_open_q),
    .fidx_o        (fidx_d),
    .loud_open_o   (loud_open_d),
    .quiet_open_o  (quiet_open_d),
    .res_o         (res)
  );

  // Advance track state once per evaluated frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fidx_q       <= '0;
      prev_q       <= '0;
      have_prev_q  <= 1'b0;
      loud_open_q  <= '0;
      quiet_open_q <= '0;
    end else if (fire) begin
      fidx_q       <= fidx_d;
      prev_q       <= stg_level_q;
      have_prev_q  <= 1'b1;
      loud_open_q  <= loud_open_d;
      quiet_open_q <= quiet_open_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loud_v_q  <= 1'b0;
      quiet_v_q <= 1'b0;
    end else if (fire) begin
      loud_v_q  <= res.loud_v;
      quiet_v_q <= res.quiet_v;
    end else if (pop) begin
      // Loud goes out first; drop whichever marker was shown
      if (loud_v_q) begin
        loud_v_q <= 1'b0;
      end else begin
        quiet_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      loud_frame_q  <= res.loud_frame;
      quiet_frame_q <= res.quiet_frame;
    end
  end

  assign out_o.valid        = loud_v_q || quiet_v_q;
  assign out_o.is_loud      = loud_v_q;
  assign out_o.marker_frame = loud_v_q ? loud_frame_q : quiet_frame_q;
  assign out_o.last_in_run  = !(loud_v_q && quiet_v_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DTTG_ASSERT(a_quiet_is_last, clk_i, rst_ni, (out_o.valid && !out_o.is_loud) |-> out_o.last_in_run, "quiet marker not last of its frame")
  `DTTG_ASSERT(a_loud_shown_next, clk_i, rst_ni, (fire && res.loud_v) |=> (out_o.valid && out_o.is_loud), "loud marker not presented after evaluation")
  `DTTG_ASSERT(a_no_overrun, clk_i, rst_ni, in_acc |-> (!stg_v_q || fire), "frame accepted over a held frame")
  `DTTG_ASSERT(a_fidx_bound, clk_i, rst_ni, fidx_q <= FI_W'(MAX_FRAMES), "frame index beyond limit")

endmodule
